// ===== rtl/core/cfce_pkg.sv =====
// types and constants shared by the command frame checksum encoder
// no dependencies

package cfce_pkg;

	// item kinds carried on the input tuser
	localparam logic CMD_HEADER = 1'b0;
	localparam logic CMD_PARAM  = 1'b1;

	// longest burst of frame bytes caused by one item
	localparam int BURST_MAX = 6;
	localparam int BURST_CW  = $clog2(BURST_MAX + 1);

	// frame byte count for the various bursts
	localparam logic [BURST_CW-1:0] CNT_NONE     = BURST_CW'(0);
	localparam logic [BURST_CW-1:0] CNT_PARAM    = BURST_CW'(1);
	localparam logic [BURST_CW-1:0] CNT_PARAM_CK = BURST_CW'(3);
	localparam logic [BURST_CW-1:0] CNT_HDR      = BURST_CW'(4);
	localparam logic [BURST_CW-1:0] CNT_HDR_CK   = BURST_CW'(6);

	// length field counts the two opcode bytes
	localparam logic [15:0] LEN_OVERHEAD = 16'd2;

	// bytes of one item, in wire order from index 0
	typedef struct packed {
		logic [BURST_MAX-1:0][7:0] bytes;
		logic [BURST_CW-1:0]       count;
		logic                      has_ck;
	} burst_t;

endpackage

// ===== rtl/core/command_frame_checksum_encoder_core.sv =====
// top level of the command frame checksum encoder
// depends on cfce_pkg, cfce_framer, cfce_serializer

// Builds a length-prefixed command frame as a byte stream. A header item
// (tuser 0) emits the length (count + 2) and the opcode, little-endian; each
// parameter item (tuser 1) passes its byte; after the last parameter, or right
// after a header with count zero, the two checksum bytes follow, the second
// with tlast. The checksum is the negated 16-bit sum of the frame read as
// little-endian words. Parameter items with no frame open are taken and
// dropped. Counts above MAX_PARAM_BYTES are clipped. An item is taken in the
// same cycle the output register hands over its final byte, so parameter
// bytes stream at one per cycle while the receiver is ready; a header occupies
// the one-byte output port for 4 bytes (6 with an empty frame) and the last
// parameter for 3 bytes. Results appear in the cycle after the input transfer.

module command_frame_checksum_encoder_core #(
	parameter int MAX_PARAM_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // opcode [15:0], param_count [22:16], param_byte [30:23]
	input  logic        s_tuser,   // cmd [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte [7:0]
	output logic        m_tlast
);
	import cfce_pkg::*;

	logic   accept;
	burst_t burst;

	assign accept = s_tvalid && s_tready;

	// frame state and burst construction
	cfce_framer #(
		.MAX_PARAM_BYTES(MAX_PARAM_BYTES)
	) u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.cmd        (s_tuser),
		.opcode     (s_tdata[15:0]),
		.param_count(s_tdata[22:16]),
		.param_byte (s_tdata[30:23]),
		.burst      (burst)
	);

	// byte-wide output stage
	cfce_serializer u_ser (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.burst   (burst),
		.can_load(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

// ===== rtl/core/cfce_framer.sv =====
// frame state and per-item burst builder: length, opcode, checksum
// depends on cfce_pkg

module cfce_framer #(
	parameter int MAX_PARAM_BYTES = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic            cmd,
	input  logic [15:0]     opcode,
	input  logic [6:0]      param_count,
	input  logic [7:0]      param_byte,
	output cfce_pkg::burst_t burst
);
	import cfce_pkg::*;

	// counts above this cannot reach the 7-bit count field
	localparam int SAT   = (MAX_PARAM_BYTES > 127) ? 127 : MAX_PARAM_BYTES;
	localparam int CNT_W = (SAT < 2) ? 1 : $clog2(SAT + 1);

	logic             open_q;
	logic [CNT_W-1:0] left_q;
	logic [15:0]      sum_q;
	logic             odd_q;

	logic [6:0]       cnt_sat;
	logic [15:0]      len;
	logic [15:0]      sum_h;
	logic [15:0]      ck_h;
	logic [15:0]      add_p;
	logic [15:0]      sum_p;
	logic [15:0]      ck_p;
	logic [CNT_W-1:0] left_dec;
	logic             done_p;

	// header arithmetic: length word plus opcode word
	always_comb begin
		cnt_sat = (32'(param_count) > SAT) ? 7'(SAT) : param_count;
		len     = 16'(cnt_sat) + LEN_OVERHEAD;
		sum_h   = len + opcode;
		ck_h    = 16'd0 - sum_h;
	end

	// parameter arithmetic: byte lands in the low or high half of a word
	always_comb begin
		add_p    = odd_q ? {param_byte, 8'h00} : {8'h00, param_byte};
		sum_p    = sum_q + add_p;
		ck_p     = 16'd0 - sum_p;
		left_dec = left_q - CNT_W'(1);
		done_p   = (left_dec == '0);
	end

	// bytes caused by the current item
	always_comb begin
		burst = '0;
		if (cmd == CMD_HEADER) begin
			burst.bytes[0] = len[7:0];
			burst.bytes[1] = len[15:8];
			burst.bytes[2] = opcode[7:0];
			burst.bytes[3] = opcode[15:8];
			burst.bytes[4] = ck_h[7:0];
			burst.bytes[5] = ck_h[15:8];
			burst.has_ck   = (cnt_sat == 7'd0);
			burst.count    = burst.has_ck ? CNT_HDR_CK : CNT_HDR;
		end else if (open_q) begin
			burst.bytes[0] = param_byte;
			burst.bytes[1] = ck_p[7:0];
			burst.bytes[2] = ck_p[15:8];
			burst.has_ck   = done_p;
			burst.count    = done_p ? CNT_PARAM_CK : CNT_PARAM;
		end else begin
			burst.count = CNT_NONE;
		end
	end

	// frame state, updated on header transfers and on parameter transfers into an open frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			left_q <= '0;
			sum_q  <= '0;
			odd_q  <= 1'b0;
		end else if (accept) begin
			if (cmd == CMD_HEADER) begin
				open_q <= (cnt_sat != 7'd0);
				left_q <= cnt_sat[CNT_W-1:0];
				sum_q  <= (cnt_sat != 7'd0) ? sum_h : 16'd0;
				odd_q  <= 1'b0;
			end else if (open_q) begin
				open_q <= !done_p;
				left_q <= left_dec;
				sum_q  <= done_p ? 16'd0 : sum_p;
				odd_q  <= done_p ? 1'b0 : !odd_q;
			end
		end
	end

endmodule

// ===== rtl/core/cfce_serializer.sv =====
// output register that plays out one burst a byte per transfer
// depends on cfce_pkg

module cfce_serializer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  cfce_pkg::burst_t burst,
	output logic             can_load,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,  // out_byte [7:0]
	output logic             m_tlast
);
	import cfce_pkg::*;

	logic [BURST_MAX-1:0][7:0] bytes_s1;
	logic [BURST_CW-1:0]       cnt_q;
	logic                      ck_q;
	logic                      xfer;

	assign xfer     = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != CNT_NONE);
	assign m_tdata  = bytes_s1[0];
	assign m_tlast  = ck_q && (cnt_q == CNT_PARAM);
	// free now, or giving away its final byte in this cycle
	assign can_load = (cnt_q == CNT_NONE) || ((cnt_q == CNT_PARAM) && m_tready);

	// remaining byte count and checksum flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_NONE;
			ck_q  <= 1'b0;
		end else if (load) begin
			cnt_q <= burst.count;
			ck_q  <= burst.has_ck;
		end else if (xfer) begin
			cnt_q <= cnt_q - BURST_CW'(1);
		end
	end

	// byte shift register, head is on the wire
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s1 <= burst.bytes;
		end else if (xfer) begin
			bytes_s1 <= {8'h00, bytes_s1[BURST_MAX-1:1]};
		end
	end

endmodule

// ===== rtl/core/cfce_checker.sv =====
// port-level checks for the command frame checksum encoder
// depends on cfce_pkg and command_frame_checksum_encoder_core (bound to it)

module cfce_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);
	import cfce_pkg::*;

	// stalled output transfer holds its byte
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	// an empty output stage always takes input
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output stage");

	// a stalled output blocks new input
	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	// a header starts with a length byte, never the frame end
	a_hdr_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_HEADER) |=> m_tvalid && !m_tlast)
		else $error("header transfer produced no leading byte");

endmodule

bind command_frame_checksum_encoder_core cfce_checker u_cfce_checker (.*);

// ===== tb/sv/tb_command_frame_checksum_encoder_core.sv =====
// self-checking testbench for command_frame_checksum_encoder_core
// depends on cfce_pkg and the encoder rtl; directed table, then random frames
// checked against a built-in frame encoder

module tb_command_frame_checksum_encoder_core;

	import cfce_pkg::*;

	localparam int MAX_PARAMS    = 64;
	localparam int IDLE_PCT      = 23;
	localparam int RANDOM_ITEMS  = 140;
	localparam int DRAIN_CYCLES  = 16;
	localparam int HOLD_CYCLES   = 150;
	localparam int HOLD_AT_BYTE  = 80;

	// one byte on the wire with its frame end flag
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} wire_byte_t;

	// one input transfer, optionally with its bytes written out by hand
	typedef struct packed {
		logic                      cmd;
		logic [15:0]               opcode;
		logic [6:0]                count;
		logic [7:0]                pbyte;
		logic                      typed;
		logic [2:0]                n;
		logic [BURST_MAX-1:0][7:0] bytes;
	} cmd_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // opcode [15:0], param_count [22:16], param_byte [30:23]
	logic        s_tuser;   // cmd [0]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // out_byte [7:0]
	logic        m_tlast;

	// frame encoder state
	logic        frame_open;
	logic [6:0]  params_left;
	logic [15:0] word_sum;
	logic        odd_byte;
	wire_byte_t  burst [0:BURST_MAX-1];
	int          burst_len;

	wire_byte_t  expected_wire_q [$];
	wire_byte_t  exp_byte;
	cmd_item_t   directed_rows [$];
	int          mismatches;
	int          wire_bytes_seen;
	int          gap_pct;

	command_frame_checksum_encoder_core #(
		.MAX_PARAM_BYTES(MAX_PARAMS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	// 4 unit clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// append one byte to the current burst, optionally adding it into the word sum
	function automatic void put_wire_byte(input logic [7:0] b, input logic last_flag,
			input logic summed);
		if (summed) begin
			word_sum = odd_byte ? word_sum + {b, 8'h00} : word_sum + {8'h00, b};
			odd_byte = !odd_byte;
		end
		burst[burst_len] = '{b, last_flag};
		burst_len++;
	endfunction

	// bytes caused by one accepted item, updating the frame state
	function automatic void encode_frame_item(input cmd_item_t it);
		logic [6:0]  n;
		logic [15:0] len;
		logic [15:0] ck;
		burst_len = 0;
		if (it.cmd == CMD_HEADER) begin
			n = (it.count > MAX_PARAMS) ? 7'(MAX_PARAMS) : it.count;
			len = {9'd0, n} + LEN_OVERHEAD;
			word_sum = 16'd0;
			odd_byte = 1'b0;
			put_wire_byte(len[7:0], 1'b0, 1'b1);
			put_wire_byte(len[15:8], 1'b0, 1'b1);
			put_wire_byte(it.opcode[7:0], 1'b0, 1'b1);
			put_wire_byte(it.opcode[15:8], 1'b0, 1'b1);
			frame_open = 1'b1;
			params_left = n;
		end else if (frame_open) begin
			put_wire_byte(it.pbyte, 1'b0, 1'b1);
			if (params_left != 7'd0)
				params_left--;
		end else begin
			return;
		end
		// frame complete: append negated word sum
		if (params_left == 7'd0) begin
			ck = 16'd0 - word_sum;
			put_wire_byte(ck[7:0], 1'b0, 1'b0);
			put_wire_byte(ck[15:8], 1'b1, 1'b0);
			frame_open = 1'b0;
			word_sum = 16'd0;
			odd_byte = 1'b0;
		end
	endfunction

	// offer one item until transferred, then queue its bytes
	task automatic drive_item(input cmd_item_t it);
		logic taken;
		int   i;
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.cmd;
		s_tdata  <= {1'b0, it.pbyte, it.count, it.opcode};
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		encode_frame_item(it);
		if (it.typed) begin
			for (i = 0; i < it.n; i++)
				expected_wire_q.push_back('{it.bytes[i], logic'(i == it.n - 1)});
		end else begin
			for (i = 0; i < burst_len; i++)
				expected_wire_q.push_back(burst[i]);
		end
	endtask

	// stop offering until every queued byte has come out
	task automatic wait_all_bytes_out;
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (expected_wire_q.size() != 0);
	endtask

	// receiver: random stalls, one long hold-off, one stretch without stalls
	initial begin : receiver
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (!hold_done && wire_bytes_seen >= HOLD_AT_BYTE) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (wire_bytes_seen >= 150 && wire_bytes_seen < 300) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// output check, sampled midway between edges
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			wire_bytes_seen++;
			if (expected_wire_q.size() == 0) begin
				$error("unexpected output byte %02h last %0b", m_tdata, m_tlast);
				mismatches++;
			end else begin
				exp_byte = expected_wire_q.pop_front();
				if (m_tdata !== exp_byte.data) begin
					$error("out_byte: expected %02h, got %02h", exp_byte.data, m_tdata);
					mismatches++;
				end
				if (m_tlast !== exp_byte.last) begin
					$error("last: expected %0b, got %0b", exp_byte.last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// overall time limit
	initial begin
		#400000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : stimulus
		cmd_item_t it;
		int        items_sent;
		int        frame_idx;
		int        n;
		int        k;
		int        r;
		frame_open = 1'b0;
		params_left = 7'd0;
		word_sum = 16'd0;
		odd_byte = 1'b0;
		mismatches = 0;
		wire_bytes_seen = 0;
		gap_pct = IDLE_PCT;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = CMD_HEADER;
		s_tdata = 32'd0;

		// cmd, opcode, count, byte, typed, n, bytes (first byte lowest)
		// parameter with no frame open after reset: dropped
		directed_rows.push_back('{CMD_PARAM, 16'h0000, 7'd0, 8'hA5, 1'b1, 3'd0, 48'h0});
		// empty frames: all-zero opcode, all-ones opcode, sum wrapping to zero
		directed_rows.push_back('{CMD_HEADER, 16'h0000, 7'd0, 8'h00, 1'b1, 3'd6,
			48'hFF_FE_00_00_00_02});
		directed_rows.push_back('{CMD_HEADER, 16'hFFFF, 7'd0, 8'hFF, 1'b1, 3'd6,
			48'hFF_FF_FF_FF_00_02});
		directed_rows.push_back('{CMD_HEADER, 16'hFFFE, 7'd0, 8'h00, 1'b1, 3'd6,
			48'h00_00_FF_FE_00_02});
		// dropped parameter after a closed frame
		directed_rows.push_back('{CMD_PARAM, 16'hFFFF, 7'd127, 8'h5A, 1'b1, 3'd0, 48'h0});
		// count above the limit, then abandoned by a new header
		directed_rows.push_back('{CMD_HEADER, 16'hA55A, 7'd127, 8'hFF, 1'b0, 3'd0, 48'h0});
		directed_rows.push_back('{CMD_PARAM, 16'h0000, 7'd0, 8'h00, 1'b0, 3'd0, 48'h0});
		directed_rows.push_back('{CMD_PARAM, 16'hFFFF, 7'd127, 8'hFF, 1'b0, 3'd0, 48'h0});
		directed_rows.push_back('{CMD_HEADER, 16'h5AA5, 7'd3, 8'h00, 1'b0, 3'd0, 48'h0});
		directed_rows.push_back('{CMD_PARAM, 16'h0000, 7'd0, 8'h80, 1'b0, 3'd0, 48'h0});
		directed_rows.push_back('{CMD_PARAM, 16'h0000, 7'd0, 8'h01, 1'b0, 3'd0, 48'h0});
		directed_rows.push_back('{CMD_PARAM, 16'h0000, 7'd0, 8'h7F, 1'b0, 3'd0, 48'h0});
		directed_rows.push_back('{CMD_PARAM, 16'h0000, 7'd0, 8'h33, 1'b1, 3'd0, 48'h0});
		directed_rows.push_back('{CMD_HEADER, 16'h00FF, 7'd1, 8'h00, 1'b0, 3'd0, 48'h0});
		directed_rows.push_back('{CMD_PARAM, 16'h0000, 7'd0, 8'h55, 1'b0, 3'd0, 48'h0});
		// one above the limit, then exactly the limit, both abandoned
		directed_rows.push_back('{CMD_HEADER, 16'hFF00, 7'd65, 8'h00, 1'b0, 3'd0, 48'h0});
		directed_rows.push_back('{CMD_PARAM, 16'h0000, 7'd0, 8'hAA, 1'b0, 3'd0, 48'h0});
		directed_rows.push_back('{CMD_HEADER, 16'h8001, 7'd64, 8'h00, 1'b0, 3'd0, 48'h0});
		directed_rows.push_back('{CMD_PARAM, 16'h0000, 7'd0, 8'hFF, 1'b0, 3'd0, 48'h0});
		directed_rows.push_back('{CMD_HEADER, 16'h1234, 7'd2, 8'h00, 1'b0, 3'd0, 48'h0});
		directed_rows.push_back('{CMD_PARAM, 16'h0000, 7'd0, 8'hFF, 1'b0, 3'd0, 48'h0});
		directed_rows.push_back('{CMD_PARAM, 16'h0000, 7'd0, 8'hFF, 1'b0, 3'd0, 48'h0});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			drive_item(directed_rows[i]);
		wait_all_bytes_out();

		// random frames: mostly complete, some cut short, some stray bytes
		items_sent = 0;
		frame_idx = 0;
		while (items_sent < RANDOM_ITEMS) begin
			gap_pct = (items_sent >= 40 && items_sent < 100) ? 0 : IDLE_PCT;
			r = $urandom_range(0, 99);
			it.typed = 1'b0;
			it.n = 3'd0;
			it.bytes = '0;
			it.opcode = 16'($urandom);
			it.count = 7'($urandom);
			it.pbyte = 8'($urandom);
			if (r < 8) begin
				it.cmd = CMD_PARAM;
				if (frame_open)
					items_sent++;
				drive_item(it);
			end else begin
				it.cmd = CMD_HEADER;
				if (frame_idx == 5 || $urandom_range(0, 99) < 3)
					it.count = 7'($urandom_range(64, 127));
				else
					it.count = 7'($urandom_range(0, 8));
				n = (it.count > MAX_PARAMS) ? MAX_PARAMS : int'(it.count);
				if (r < 20 && n >= 2)
					n = $urandom_range(1, n - 1);
				drive_item(it);
				items_sent++;
				for (k = 0; k < n; k++) begin
					it.cmd = CMD_PARAM;
					it.opcode = 16'($urandom);
					it.count = 7'($urandom);
					it.pbyte = 8'($urandom);
					drive_item(it);
					items_sent++;
				end
				frame_idx++;
			end
		end

		wait_all_bytes_out();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_wire_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
